FILE: rtl/bounded_unsorted_key_list_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key list core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNSORTED_KEY_LIST_CORE_MACROS_SVH
`define BOUNDED_UNSORTED_KEY_LIST_CORE_MACROS_SVH

// Same-cycle implication
`define BUKL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BUKL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bukl_pkg.sv
// ----------------------------------------------------------------------------
// bukl_pkg
// Shared constants of the bounded unsorted key list.
// ----------------------------------------------------------------------------
package bukl_pkg;

  // Default sizing
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed port widths
  localparam int MODE_W = 2;
  localparam int KEY_W  = 32;
  localparam int LEN_W  = 7;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

endpackage

FILE: rtl/bukl_ram.sv
// ----------------------------------------------------------------------------
// bukl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bukl_ram #(
  parameter int WIDTH = bukl_pkg::KEY_BITS_DEF,
  parameter int DEPTH = bukl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bounded_unsorted_key_list_core.sv
// ----------------------------------------------------------------------------
// bounded_unsorted_key_list_core
// Unordered store of up to MAX_ENTRIES keys with insert, search, delete, clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_mode and in_key; an item is
//   taken when in_valid is high and in_stall is low. Each item yields exactly
//   one result on out_valid/out_stall: out_ok, out_item, out_length.
//   Keys sit in one RAM (one write, one registered read port); a count
//   register holds the fill level.
// Sequencing:
//   insert and clear: result on the output in the cycle after the item is taken.
//   search: a scan reads one entry per cycle through the RAM read port and
//     compares it with the key; the result comes at the first match or once
//     every entry below count is compared.
//   delete hit: then ST_LAST reads the last entry and ST_MOVE writes it into
//     the freed slot; delete miss costs the same as a search miss.
//   One item is worked on at a time: a new item is not taken until the
//   result of the last one is registered.
// Reset: count is cleared; RAM contents are not, and never read past count.
// Stall: while a result waits under out_stall, in_stall stays high; a result
//   taken in the same cycle frees the output register for the next item.
// ----------------------------------------------------------------------------
`include "bounded_unsorted_key_list_core_macros.svh"

module bounded_unsorted_key_list_core #(
  parameter int MAX_ENTRIES = bukl_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = bukl_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bukl_pkg::MODE_W-1:0]   in_mode,
  input  logic [bukl_pkg::KEY_W-1:0]    in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic [bukl_pkg::KEY_W-1:0]    out_item,
  output logic [bukl_pkg::LEN_W-1:0]    out_length
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2((MAX_ENTRIES > 1) ? MAX_ENTRIES : 2);
  localparam int KW = (KEY_BITS < bukl_pkg::KEY_W) ? KEY_BITS : bukl_pkg::KEY_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_MOVE = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        cmp_valid_r, cmp_valid_nxt;
  logic [AW-1:0]               cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]               slot_r, slot_nxt;
  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [bukl_pkg::KEY_W-1:0]  raw_r, raw_nxt;
  logic                        del_r, del_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r, out_ok_nxt;
  logic [bukl_pkg::KEY_W-1:0]  out_item_r, out_item_nxt;
  logic [bukl_pkg::LEN_W-1:0]  out_length_r, out_length_nxt;

  logic                        in_fire;
  logic [KEY_BITS-1:0]         key_in;
  logic                        res_fire;
  logic                        res_ok;
  logic [bukl_pkg::KEY_W-1:0]  res_item;
  logic                        issue_ok;
  logic                        hit;
  logic [CW-1:0]               last_idx;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [KEY_BITS-1:0]         mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [KEY_BITS-1:0]         mem_rdata;

  // Handshake: one item in flight, output register must be free or draining
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;

  // Key as stored: low KEY_BITS bits, zero-extended if KEY_BITS is wider
  assign key_in = KEY_BITS'(in_key[KW-1:0]);

  // Scan pipeline: issue index idx_r, compare the returned entry in the following cycle
  assign issue_ok = (state_r == ST_SCAN) && (idx_r < count_r);
  assign hit      = cmp_valid_r && (mem_rdata == key_r);
  assign last_idx = count_r - CW'(1);

  // Key store
  bukl_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_valid_nxt = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    slot_nxt      = slot_r;
    key_nxt       = key_r;
    raw_nxt       = raw_r;
    del_nxt       = del_r;
    res_fire      = 1'b0;
    res_ok        = 1'b0;
    res_item      = raw_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = key_in;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          key_nxt  = key_in;
          raw_nxt  = in_key;
          res_item = in_key;
          unique case (in_mode)
            bukl_pkg::MODE_INSERT: begin
              res_fire = 1'b1;
              if (count_r < CW'(MAX_ENTRIES)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                res_ok    = 1'b1;
              end
            end
            bukl_pkg::MODE_SEARCH, bukl_pkg::MODE_DELETE: begin
              del_nxt   = (in_mode == bukl_pkg::MODE_DELETE);
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            bukl_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              res_ok    = 1'b1;
              res_fire  = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        mem_re        = issue_ok;
        cmp_valid_nxt = issue_ok && !hit;
        cmp_idx_nxt   = idx_r[AW-1:0];
        if (issue_ok) begin
          idx_nxt = idx_r + CW'(1);
        end
        priority if (hit && !del_r) begin
          // search hit: report the stored entry
          res_fire  = 1'b1;
          res_ok    = 1'b1;
          res_item  = bukl_pkg::KEY_W'(key_r[KW-1:0]);
          state_nxt = ST_IDLE;
        end else if (hit) begin
          slot_nxt  = cmp_idx_r;
          state_nxt = ST_LAST;
        end else if (!issue_ok) begin
          // every entry compared, no match
          res_fire  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // keep scanning
          state_nxt = ST_SCAN;
        end
      end

      // Fetch the last entry to fill the gap
      ST_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = last_idx[AW-1:0];
        state_nxt = ST_MOVE;
      end

      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = mem_rdata;
        count_nxt = last_idx;
        res_fire  = 1'b1;
        res_ok    = 1'b1;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt  = res_fire || (out_valid_r && out_stall);
    out_ok_nxt     = out_ok_r;
    out_item_nxt   = out_item_r;
    out_length_nxt = out_length_r;
    if (res_fire) begin
      out_ok_nxt     = res_ok;
      out_item_nxt   = res_item;
      out_length_nxt = bukl_pkg::LEN_W'(count_nxt);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    slot_r       <= slot_nxt;
    key_r        <= key_nxt;
    raw_r        <= raw_nxt;
    del_r        <= del_nxt;
    out_ok_r     <= out_ok_nxt;
    out_item_r   <= out_item_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_item   = out_item_r;
  assign out_length = out_length_r;

  // Checks
  `BUKL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_ENTRIES), "count above capacity")
  `BUKL_ASSERT_NOW(a_no_overwrite, res_fire, !(out_valid_r && out_stall),
                   "result overwrites waiting result")
  `BUKL_ASSERT_NOW(a_busy_stall, state_r != ST_IDLE, in_stall, "item taken while busy")
  `BUKL_ASSERT_NEXT(a_delete_count, state_r == ST_MOVE,
                    count_r == $past(count_r) - CW'(1), "delete did not shrink count")
  `BUKL_ASSERT_NOW(a_write_src, mem_we,
                   (state_r == ST_MOVE) ||
                   (state_r == ST_IDLE && in_fire && in_mode == bukl_pkg::MODE_INSERT),
                   "unexpected RAM write")

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the unordered key list core. A short table of
// directed items covers the empty store, extreme keys, duplicates, misses and
// clear. Random phases follow that fill the store past full, drain it and mix
// operations. Results are checked against typed rows or an in-bench store copy.
// ----------------------------------------------------------------------------
module testbench;
  import bukl_pkg::*;

  localparam int LIST_DEPTH    = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = LIST_DEPTH + 16;
  localparam int REPORT_MAX    = 10;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 300;
  localparam int DIRECTED_ROWS = 21;
  localparam bit FROM_TABLE    = 1'b1;
  localparam bit FROM_MODEL    = 1'b0;

  // Phases of the random part
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_kind_t;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] item;
    logic [LEN_W-1:0] length;
  } list_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic              typed;
    list_result_t      res;
  } list_row_t;

  // DUT ports
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode    = MODE_INSERT;
  logic [KEY_W-1:0]  in_key     = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic              out_ok;
  logic [KEY_W-1:0]  out_item;
  logic [LEN_W-1:0]  out_length;

  // Shadow copy of the key store
  logic [KEY_BITS_DEF-1:0] shadow_keys [LIST_DEPTH];
  int                      shadow_fill = 0;

  list_result_t pending_results [$];
  list_row_t    directed_rows [DIRECTED_ROWS];
  int           mismatches     = 0;
  int           results_done   = 0;
  int           cycle_count    = 0;

  bounded_unsorted_key_list_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_ok     (out_ok),
    .out_item   (out_item),
    .out_length (out_length)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Apply one operation to the shadow store, return the expected result
  function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] mode,
                                                 input logic [KEY_W-1:0] key);
    list_result_t            res;
    logic [KEY_BITS_DEF-1:0] k;
    int                      slot;
    k    = key[KEY_BITS_DEF-1:0];
    slot = -1;
    res  = '{ok: 1'b0, item: key, length: '0};
    if (mode == MODE_SEARCH || mode == MODE_DELETE) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (slot < 0 && shadow_keys[i] == k) slot = i;
      end
    end
    case (mode)
      MODE_INSERT: begin
        if (shadow_fill < LIST_DEPTH) begin
          shadow_keys[shadow_fill] = k;
          shadow_fill++;
          res.ok = 1'b1;
        end
      end
      MODE_SEARCH: begin
        if (slot >= 0) begin
          res.ok   = 1'b1;
          res.item = KEY_W'(shadow_keys[slot]);
        end
      end
      MODE_DELETE: begin
        // lowest match is replaced by the last entry
        if (slot >= 0) begin
          shadow_keys[slot] = shadow_keys[shadow_fill-1];
          shadow_fill--;
          res.ok = 1'b1;
        end
      end
      default: begin
        shadow_fill = 0;
        res.ok      = 1'b1;
      end
    endcase
    res.length = LEN_W'(shadow_fill);
    return res;
  endfunction

  function automatic list_row_t mk_row(input logic [MODE_W-1:0] mode,
                                       input logic [KEY_W-1:0] key, input bit typed,
                                       input logic ok, input int length);
    list_row_t row;
    row.mode  = mode;
    row.key   = key;
    row.typed = typed;
    row.res   = '{ok: ok, item: key, length: LEN_W'(length)};
    return row;
  endfunction

  // Idle gap: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("ERROR: %s", msg);
  endfunction

  // Offer one item, called at a falling edge; returns at the falling edge
  // after the item is taken
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                           input bit typed, input list_result_t typed_res);
    list_result_t predicted;
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_op(mode, key);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_done <= results_done + 1;
      got = '{ok: out_ok, item: out_item, length: out_length};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result ok=%0b item=%h length=%0d with no item pending",
                               got.ok, got.item, got.length));
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.item !== want.item || got.length !== want.length)
          note_failure($sformatf("ok %0b/%0b item %h/%h length %0d/%0d (expected/actual)",
                                 want.ok, got.ok, want.item, got.item,
                                 want.length, got.length));
      end
    end
  end

  // Receiver stall: random gaps, quiet windows, and one long hold-off
  initial begin
    int stall_left;
    int quiet_left;
    bit held_long;
    stall_left = 0;
    quiet_left = 0;
    held_long  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_long && results_done >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 149) == 0) quiet_left = 100;
        else stall_left = gap_len();
      end
    end
  end

  // Stimulus
  initial begin
    logic [KEY_W-1:0]  key_pool [16];
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    phase_kind_t       phase;
    int                phase_len;
    int                items_sent;
    int                r;
    bit                burst;

    // Directed table: typed rows are obvious from the store contents
    directed_rows[0]  = mk_row(MODE_SEARCH, 32'h12345678, FROM_TABLE, 1'b0, 0);
    directed_rows[1]  = mk_row(MODE_DELETE, 32'h00000000, FROM_TABLE, 1'b0, 0);
    directed_rows[2]  = mk_row(MODE_CLEAR,  32'hFFFFFFFF, FROM_TABLE, 1'b1, 0);
    directed_rows[3]  = mk_row(MODE_INSERT, 32'h00000000, FROM_TABLE, 1'b1, 1);
    directed_rows[4]  = mk_row(MODE_INSERT, 32'hFFFFFFFF, FROM_TABLE, 1'b1, 2);
    directed_rows[5]  = mk_row(MODE_SEARCH, 32'hFFFFFFFF, FROM_TABLE, 1'b1, 2);
    directed_rows[6]  = mk_row(MODE_SEARCH, 32'h00000000, FROM_TABLE, 1'b1, 2);
    directed_rows[7]  = mk_row(MODE_SEARCH, 32'h80000000, FROM_TABLE, 1'b0, 2);
    directed_rows[8]  = mk_row(MODE_INSERT, 32'hA5A5A5A5, FROM_MODEL, 1'b0, 0);
    directed_rows[9]  = mk_row(MODE_INSERT, 32'hA5A5A5A5, FROM_MODEL, 1'b0, 0);
    directed_rows[10] = mk_row(MODE_INSERT, 32'h5A5A5A5A, FROM_MODEL, 1'b0, 0);
    // duplicate keys: only the lowest copy goes
    directed_rows[11] = mk_row(MODE_DELETE, 32'hA5A5A5A5, FROM_MODEL, 1'b0, 0);
    directed_rows[12] = mk_row(MODE_SEARCH, 32'hA5A5A5A5, FROM_MODEL, 1'b0, 0);
    directed_rows[13] = mk_row(MODE_DELETE, 32'hFFFFFFFF, FROM_MODEL, 1'b0, 0);
    directed_rows[14] = mk_row(MODE_DELETE, 32'h5A5A5A5A, FROM_MODEL, 1'b0, 0);
    directed_rows[15] = mk_row(MODE_DELETE, 32'h00000001, FROM_MODEL, 1'b0, 0);
    directed_rows[16] = mk_row(MODE_SEARCH, 32'h5A5A5A5A, FROM_MODEL, 1'b0, 0);
    directed_rows[17] = mk_row(MODE_CLEAR,  32'h00000000, FROM_TABLE, 1'b1, 0);
    // after clear the old entries must not be seen
    directed_rows[18] = mk_row(MODE_SEARCH, 32'h00000000, FROM_TABLE, 1'b0, 0);
    directed_rows[19] = mk_row(MODE_INSERT, 32'h00000001, FROM_TABLE, 1'b1, 1);
    directed_rows[20] = mk_row(MODE_DELETE, 32'h00000001, FROM_TABLE, 1'b1, 0);

    // Reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].typed,
                directed_rows[i].res);
      idle_input(gap_len());
    end

    // Random phases with a pool of keys so that hits and duplicates occur
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase     = phase_kind_t'($urandom_range(0, 3));
      phase_len = $urandom_range(30, 140);
      burst     = ($urandom_range(0, 3) == 0);
      foreach (key_pool[k]) key_pool[k] = $urandom();
      for (int j = 0; j < phase_len && items_sent < RANDOM_ITEMS; j++) begin
        r = $urandom_range(0, 99);
        case (phase)
          PH_FILL:  mode = (r < 80) ? MODE_INSERT : (r < 90) ? MODE_SEARCH : MODE_DELETE;
          PH_DRAIN: mode = (r < 1) ? MODE_CLEAR : (r < 60) ? MODE_DELETE :
                           (r < 90) ? MODE_SEARCH : MODE_INSERT;
          PH_MIXED: mode = (r < 1) ? MODE_CLEAR : (r < 40) ? MODE_INSERT :
                           (r < 70) ? MODE_SEARCH : MODE_DELETE;
          default:  mode = MODE_W'($urandom_range(0, 3));
        endcase
        if (phase == PH_NOISE)
          key = $urandom();
        else if (mode != MODE_INSERT && shadow_fill > 0 && $urandom_range(0, 9) < 6)
          key = KEY_W'(shadow_keys[$urandom_range(0, shadow_fill - 1)]);
        else if ($urandom_range(0, 7) == 0)
          key = $urandom();
        else
          key = key_pool[$urandom_range(0, 15)];
        send_item(mode, key, FROM_MODEL, '0);
        idle_input(burst ? 0 : gap_len());
        items_sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
